// ===== sv/tsc_pkg.sv =====
// ----------------------------------------------------------------------------
// tsc_pkg: shared types and constants for the Taylor sine/cosine block
// Widths, fixed-point constants, controller states and command/status structs.
// ----------------------------------------------------------------------------
`default_nettype none

package tsc_pkg;

  // Payload widths
  localparam int unsigned ANGLE_W = 16;
  localparam int unsigned TERM_W  = 3;
  localparam int unsigned RES_W   = 48;

  localparam logic [TERM_W-1:0] MAX_TERM_INDEX = 3'd5;

  // Fixed-point arithmetic
  localparam int unsigned FRAC_BITS = 32;
  localparam int unsigned RAD_NUM   = 157;   // 2 * 3.14 / 360 = 157 / 9000
  localparam int unsigned RAD_DEN   = 9000;
  localparam int unsigned FULL_TURN = 360;

  // Angle reduction: compare and subtract 360 * 2^j, j from MOD_HI_TOP down to 0.
  // 360 * 2^7 exceeds the largest magnitude, 32768.
  localparam int MOD_HI_TOP = 6;             // upper steps, in ST_MOD_HI: j = 6 .. 3
  localparam int MOD_LO_TOP = 2;             // lower steps, in ST_MOD_LO: j = 2 .. 0

  localparam int unsigned MAG_W  = 40;       // term magnitude, Q.32, below 2^39
  localparam int unsigned AC_W   = 16;       // reduced degrees * 157
  localparam int unsigned MODR_W = 9;        // remainder mod 360
  localparam int unsigned NUM_W  = MAG_W + AC_W;
  localparam int unsigned DEN_W  = 17;       // 9000 * k for k up to 11
  localparam int unsigned K_W    = TERM_W + 1;

  // Shared divider: radix 2, several steps per clock
  localparam int unsigned DIV_STEPS = 4;
  localparam int unsigned DIV_ITERS = NUM_W / DIV_STEPS;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_ITERS);

  typedef logic signed [ANGLE_W-1:0] angle_t;
  typedef logic        [TERM_W-1:0]  term_t;
  typedef logic signed [RES_W-1:0]   res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD_HI,
    ST_MOD_LO,
    ST_MUL,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_DONE
  } tsc_state_e;

  typedef struct packed {
    logic load;         // capture a new item, set up the k = 0 term
    logic div_start;    // launch the shared divider
    logic mod_hi;       // upper reduction steps on the angle magnitude
    logic mod_lo;       // lower reduction steps, form reduced angle factor
    logic mul;          // magnitude times reduced angle factor
    logic term_done;    // take the new magnitude, add the term to its sum
    logic out_load;     // move finished sums into the output register
  } tsc_cmd_t;

  typedef struct packed {
    logic div_done;
    logic last_term;
  } tsc_sts_t;

  // Divisor of term k: 9000 * k
  function automatic logic [DEN_W-1:0] den_of(input logic [K_W-1:0] k);
    logic [DEN_W-1:0] kx;
    kx = {{(DEN_W-K_W){1'b0}}, k};
    return kx * DEN_W'(RAD_DEN);
  endfunction

endpackage

`default_nettype wire

// ===== sv/tsc_if.sv =====
// ----------------------------------------------------------------------------
// tsc_if: valid/ready channels of the Taylor sine/cosine block
// Input channel carries angle and term index, output channel both sums.
// ----------------------------------------------------------------------------
`default_nettype none

interface tsc_in_if;
  import tsc_pkg::*;
  logic   valid;
  logic   ready;
  angle_t angle_degrees;
  term_t  term_index;

  modport source (output valid, output angle_degrees, output term_index, input ready);
  modport sink   (input valid, input angle_degrees, input term_index, output ready);
endinterface

interface tsc_out_if;
  import tsc_pkg::*;
  logic valid;
  logic ready;
  res_t sine_value;
  res_t cosine_value;

  modport source (output valid, output sine_value, output cosine_value, input ready);
  modport sink   (input valid, input sine_value, input cosine_value, output ready);
endinterface

`default_nettype wire

// ===== sv/tsc_div.sv =====
// ----------------------------------------------------------------------------
// tsc_div: multi-cycle unsigned restoring divider
// Retires DIV_STEPS quotient bits per clock; done pulses once when finished.
// ----------------------------------------------------------------------------
`default_nettype none

module tsc_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [tsc_pkg::NUM_W-1:0]         dividend_i,
  input  logic [tsc_pkg::DEN_W-1:0]         divisor_i,
  output logic                              done_o,
  output logic [tsc_pkg::NUM_W-1:0]         quo_o
);
  import tsc_pkg::*;

  logic                 busy_q, done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DEN_W-1:0]     rem_q, div_q, rem_c;
  logic [NUM_W-1:0]     quo_q, quo_c;

  always_comb begin
    logic [DEN_W:0] t;
    rem_c = rem_q;
    quo_c = quo_q;
    for (int i = 0; i < DIV_STEPS; i++) begin
      t     = {rem_c, quo_c[NUM_W-1]};
      quo_c = {quo_c[NUM_W-2:0], 1'b0};
      // partial remainder stays below the divisor, so one subtract suffices
      if (t >= {1'b0, div_q}) begin
        t        = t - {1'b0, div_q};
        quo_c[0] = 1'b1;
      end
      rem_c = t[DEN_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && (cnt_q == DIV_CNT_W'(DIV_ITERS - 1))) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      div_q <= divisor_i;
      cnt_q <= '0;
    end else if (busy_q) begin
      rem_q <= rem_c;
      quo_q <= quo_c;
      cnt_q <= cnt_q + 1'b1;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

// ===== sv/tsc_datapath.sv =====
// ----------------------------------------------------------------------------
// tsc_datapath: term recurrence, sums and output register
// One multiplier and the shared divider build each term from the previous.
// ----------------------------------------------------------------------------
`default_nettype none

module tsc_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tsc_pkg::tsc_cmd_t cmd_i,
  input  tsc_pkg::angle_t   angle_i,
  input  tsc_pkg::term_t    term_i,
  output tsc_pkg::tsc_sts_t sts_o,
  output tsc_pkg::res_t     sine_o,
  output tsc_pkg::res_t     cosine_o
);
  import tsc_pkg::*;

  logic                neg_q;
  logic [ANGLE_W-1:0]  deg_q, deg_in;
  logic [TERM_W-1:0]   n_q;
  logic [K_W-1:0]      k_q;
  logic [AC_W-1:0]     ac_q;
  logic [MAG_W-1:0]    mag_q;
  logic [NUM_W-1:0]    prod_q;
  logic [RES_W-1:0]    sin_acc_q, cos_acc_q, sine_q, cosine_q;

  logic                div_done;
  logic [NUM_W-1:0]    div_quo, div_dividend;
  logic [DEN_W-1:0]    div_divisor, den_k;
  logic [ANGLE_W-1:0]  mod_hi_c, mod_lo_c;
  logic                term_neg;
  logic [RES_W-1:0]    term_mag, term_val;

  // magnitude of the angle; the most negative code maps to 32768
  assign deg_in = angle_i[ANGLE_W-1] ? (~angle_i + 1'b1) : angle_i;

  // reduction mod 360 by compare and subtract, split over ST_MOD_HI and ST_MOD_LO
  always_comb begin
    mod_hi_c = deg_q;
    for (int j = MOD_HI_TOP; j > MOD_LO_TOP; j--) begin
      if (mod_hi_c >= ANGLE_W'(FULL_TURN << j)) begin
        mod_hi_c = mod_hi_c - ANGLE_W'(FULL_TURN << j);
      end
    end
    mod_lo_c = deg_q;
    for (int j = MOD_LO_TOP; j >= 0; j--) begin
      if (mod_lo_c >= ANGLE_W'(FULL_TURN << j)) begin
        mod_lo_c = mod_lo_c - ANGLE_W'(FULL_TURN << j);
      end
    end
  end

  assign den_k        = den_of(k_q);
  assign div_dividend = prod_q + NUM_W'(den_k >> 1);
  assign div_divisor  = den_k;

  tsc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quo_o      (div_quo)
  );

  // sign of term k: (-1)^(k/2), flipped again for odd k of a negative angle
  assign term_neg = k_q[1] ^ (neg_q & k_q[0]);
  assign term_mag = {{(RES_W-MAG_W){1'b0}}, div_quo[MAG_W-1:0]};
  assign term_val = term_neg ? (~term_mag + 1'b1) : term_mag;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      neg_q     <= angle_i[ANGLE_W-1];
      deg_q     <= deg_in;
      n_q       <= (term_i > MAX_TERM_INDEX) ? MAX_TERM_INDEX : term_i;
      k_q       <= K_W'(1);
      mag_q     <= MAG_W'(1) << FRAC_BITS;
      sin_acc_q <= '0;
      cos_acc_q <= RES_W'(1) << FRAC_BITS;   // k = 0 term of cosine
    end
    if (cmd_i.mod_hi) begin
      deg_q <= mod_hi_c;
    end
    if (cmd_i.mod_lo) begin
      ac_q <= {{(AC_W-MODR_W){1'b0}}, mod_lo_c[MODR_W-1:0]} * AC_W'(RAD_NUM);
    end
    if (cmd_i.mul) begin
      prod_q <= {{AC_W{1'b0}}, mag_q} * {{MAG_W{1'b0}}, ac_q};
    end
    if (cmd_i.term_done) begin
      mag_q <= div_quo[MAG_W-1:0];
      k_q   <= k_q + 1'b1;
      if (k_q[0]) begin
        sin_acc_q <= sin_acc_q + term_val;
      end else begin
        cos_acc_q <= cos_acc_q + term_val;
      end
    end
    if (cmd_i.out_load) begin
      sine_q   <= sin_acc_q;
      cosine_q <= cos_acc_q;
    end
  end

  assign sts_o.div_done  = div_done;
  assign sts_o.last_term = (k_q == {n_q, 1'b1});

  assign sine_o   = $signed(sine_q);
  assign cosine_o = $signed(cosine_q);

endmodule

`default_nettype wire

// ===== sv/tsc_ctrl.sv =====
// ----------------------------------------------------------------------------
// tsc_ctrl: sequencer of the Taylor sine/cosine block
// Steps angle reduction and each term, and owns both handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module tsc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  tsc_pkg::tsc_sts_t sts_i,
  output tsc_pkg::tsc_cmd_t cmd_o
);
  import tsc_pkg::*;

  tsc_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_MOD_HI;
        end
      end
      ST_MOD_HI: begin
        cmd_o.mod_hi = 1'b1;
        state_d      = ST_MOD_LO;
      end
      ST_MOD_LO: begin
        cmd_o.mod_lo = 1'b1;
        state_d      = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_DIV_START;
      end
      ST_DIV_START: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.term_done = 1'b1;
          state_d         = sts_i.last_term ? ST_DONE : ST_MUL;
        end
      end
      ST_DONE: begin
        // wait until the output register is free or being emptied
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    priority if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== sv/taylor_sine_cosine.sv =====
// Sequence per item: load, upper and lower angle reduction, then for each
//   term k = 1 .. 2n + 1 (n the saturated term index) a multiply and a
//   division on the shared divider (4 quotient bits per clock). The next item
//   is taken only once the finished sums move into the output register.
// A finished result waits in the output register while the next item runs.
// Reset (rst_ni low, asynchronous) idles the sequencer and drops output valid.
// ----------------------------------------------------------------------------
// taylor_sine_cosine: Taylor-series sine and cosine of an angle in degrees
// Angle reduced mod 360, sums of terms 0..2n+1 in signed Q15.32.
// ----------------------------------------------------------------------------
`default_nettype none

module taylor_sine_cosine (
  input  logic      clk_i,
  input  logic      rst_ni,
  tsc_in_if.sink    in_i,
  tsc_out_if.source out_o
);
  import tsc_pkg::*;

  tsc_cmd_t cmd;
  tsc_sts_t sts;

  tsc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tsc_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .angle_i  (in_i.angle_degrees),
    .term_i   (in_i.term_index),
    .sts_o    (sts),
    .sine_o   (out_o.sine_value),
    .cosine_o (out_o.cosine_value)
  );

  // a new result never overwrites one not yet transferred
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!out_o.valid || out_o.ready))
    else $error("result loaded over a pending output");

  // one item at a time: no transfer in the cycle after an accepted item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input accepted while busy");

  // divider takes several cycles; it cannot finish right after a launch
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_start |=> !sts.div_done)
    else $error("divider finished too early");

endmodule

`default_nettype wire

// ===== dv/tsc_sincos_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tsc_sincos_checker: result checker for the Taylor sine/cosine block
// Watches both channels, works out the expected sine and cosine sums of
// every accepted angle and compares each output transfer in order.
// ----------------------------------------------------------------------------

module tsc_sincos_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  tsc_in_if           in_mon,
  tsc_out_if          out_mon,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned checked_o
);
  import tsc_pkg::*;

  typedef struct packed {
    res_t sine;
    res_t cosine;
  } sincos_t;

  sincos_t pending_sums[$];
  sincos_t want;

  // Taylor partial sums, Q.32 magnitudes rounded to nearest at each term
  function automatic sincos_t predict_sincos(input angle_t angle, input term_t idx);
    logic [16:0] deg_mag;
    logic [63:0] red_deg;
    logic [63:0] mag;
    logic [63:0] den;
    logic [63:0] term;
    logic [63:0] sin_sum;
    logic [63:0] cos_sum;
    logic        neg;
    logic        term_neg;
    term_t       n_sat;
    int          last_k;
    sincos_t     res;
    neg      = angle[ANGLE_W-1];
    deg_mag  = neg ? (17'h10000 - {1'b0, angle}) : {1'b0, angle};
    red_deg  = 64'(deg_mag) % 64'(FULL_TURN);
    n_sat    = (idx > MAX_TERM_INDEX) ? MAX_TERM_INDEX : idx;
    last_k   = 2 * int'(n_sat) + 1;
    mag      = 64'd1 << FRAC_BITS;
    sin_sum  = '0;
    cos_sum  = '0;
    for (int k = 0; k <= last_k; k++) begin
      if (k > 0) begin
        den = 64'(RAD_DEN) * 64'(k);
        mag = (mag * red_deg * 64'(RAD_NUM) + den / 2) / den;
      end
      // sign alternates every two terms; odd (sine) terms follow the angle sign
      term_neg = k[1] ^ (neg & k[0]);
      term     = term_neg ? (64'd0 - mag) : mag;
      if (k[0]) begin
        sin_sum += term;
      end else begin
        cos_sum += term;
      end
    end
    res.sine   = sin_sum[RES_W-1:0];
    res.cosine = cos_sum[RES_W-1:0];
    return res;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      // output side first: a result never belongs to an angle taken this cycle
      if (out_mon.valid && out_mon.ready) begin
        if (pending_sums.size() == 0) begin
          $error("result transfer with nothing outstanding: sine %0d cosine %0d",
                 out_mon.sine_value, out_mon.cosine_value);
          fail_count_o++;
        end else begin
          want = pending_sums.pop_front();
          checked_o++;
          if (out_mon.sine_value !== want.sine) begin
            $error("sine_value mismatch: expected %0d, actual %0d",
                   want.sine, out_mon.sine_value);
            fail_count_o++;
          end
          if (out_mon.cosine_value !== want.cosine) begin
            $error("cosine_value mismatch: expected %0d, actual %0d",
                   want.cosine, out_mon.cosine_value);
            fail_count_o++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        pending_sums.push_back(predict_sincos(in_mon.angle_degrees, in_mon.term_index));
      end
      pending_o = pending_sums.size();
    end
  end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: top level for the Taylor sine/cosine block
// Directed corner angles and term indices, then bursts of random angles with
// random gaps and a stalling receiver; the checker counts any mismatch.
// ----------------------------------------------------------------------------

module testbench;
  import tsc_pkg::*;

  localparam int unsigned RAND_ITEMS   = 1100;
  localparam int unsigned IDLE_LIMIT   = 2500;  // > max latency + longest stall + gap
  localparam int unsigned TAIL_CYCLES  = 220;
  localparam int unsigned DRAIN_EVERY  = 300;

  logic clk;
  logic rst_n;

  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned checked_count;
  int unsigned sent_count;
  int unsigned idle_cycles;

  // receiver stall pattern
  int unsigned rx_run_left;
  int unsigned rx_mode;

  tsc_in_if  in_ch ();
  tsc_out_if out_ch ();

  taylor_sine_cosine i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  tsc_sincos_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending_count),
    .checked_o    (checked_count)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Receiver: stretches of solid stall, solid ready and choppy ready
  always @(posedge clk) begin
    if (rx_run_left == 0) begin
      rx_mode     = $urandom_range(0, 9);
      rx_run_left = (rx_mode < 3) ? $urandom_range(1, 15) : $urandom_range(1, 60);
    end
    rx_run_left--;
    if (rx_mode < 3) begin
      out_ch.ready <= 1'b0;
    end else if (rx_mode < 6) begin
      out_ch.ready <= 1'b1;
    end else begin
      out_ch.ready <= ($urandom_range(0, 1) == 1);
    end
  end

  // Watchdog: cycles with no transfer on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", idle_cycles);
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Present one item and hold it until the transfer; returns at that edge
  task automatic send_item(input angle_t angle, input term_t idx);
    in_ch.valid         <= 1'b1;
    in_ch.angle_degrees <= angle;
    in_ch.term_index    <= idx;
    do @(posedge clk); while (!in_ch.ready);
    sent_count++;
  endtask

  // Called at an edge; sender idles until every result is back
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending_count != 0) @(negedge clk);
    @(posedge clk);
  endtask

  function automatic angle_t pick_angle();
    int unsigned sel;
    int          v;
    sel = $urandom_range(0, 99);
    if (sel < 45) begin
      v = int'($urandom_range(0, 65535)) - 32768;
    end else if (sel < 75) begin
      v = int'($urandom_range(0, 800)) - 400;
    end else if (sel < 85) begin
      v = (int'($urandom_range(0, 182)) - 91) * int'(FULL_TURN);
    end else if (sel < 93) begin
      v = 32767 - int'($urandom_range(0, 400));
    end else begin
      v = -32768 + int'($urandom_range(0, 400));
    end
    return angle_t'(v);
  endfunction

  angle_t corner_angles[17] = '{
    16'sd0, 16'sd360, -16'sd360, 16'sd720, 16'sd1, -16'sd1, 16'sd90, -16'sd90,
    16'sd180, -16'sd180, 16'sd270, 16'sd359, -16'sd359, -16'sd370,
    16'sd32767, -16'sd32768, 16'sd45
  };

  int unsigned burst_left;

  initial begin
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.angle_degrees <= '0;
    in_ch.term_index    <= '0;
    sent_count           = 0;
    burst_left           = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: corner angles, then every term index including the saturating ones
    foreach (corner_angles[i]) begin
      send_item(corner_angles[i], term_t'(i % 8));
    end
    for (int t = 0; t < 8; t++) begin
      send_item(-16'sd60, term_t'(t));
    end
    wait_drained();

    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
      end
      send_item(pick_angle(), term_t'($urandom_range(0, 7)));
      burst_left--;
      if (i % DRAIN_EVERY == DRAIN_EVERY - 1) begin
        wait_drained();
      end else if (burst_left == 0 && $urandom_range(0, 3) != 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d angle transfers, checked %0d sine/cosine results;",
             sent_count, checked_count);
    $display("term index 0..7 incl. saturation, angles over the full signed range.");
    if (fail_count == 0 && pending_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
